### sv/mfa_pkg.sv
`timescale 1ns / 1ps
// mfa_pkg: widths, codes and limits shared by the mixed fraction unit
// no dependencies; used by the interfaces and every module

package mfa_pkg;

    // operand field width
    localparam int OP_BITS = 8;

    // improper operand width (whole * den + num), signed
    localparam int PW      = 2 * OP_BITS + 2;
    // product width, signed
    localparam int NW      = 2 * PW;
    // magnitude width of numerator and denominator
    localparam int MAG_W   = NW - 1;
    // divider step counter
    localparam int CNT_W   = $clog2(MAG_W + 1);
    // gcd common power-of-two counter
    localparam int SH_W    = $clog2(MAG_W + 1);

    // result field widths
    localparam int WHOLE_W = 26;
    localparam int NUM_W   = 17;
    localparam int DEN_W   = 16;

    localparam logic [MAG_W-1:0] DEN_MAX       = MAG_W'((2 ** DEN_W) - 1);
    localparam logic [MAG_W-1:0] WHOLE_POS_MAX = MAG_W'((2 ** (WHOLE_W - 1)) - 1);
    localparam logic [MAG_W-1:0] WHOLE_NEG_MAX = MAG_W'(2 ** (WHOLE_W - 1));

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

endpackage

### sv/mfa_if.sv
`timescale 1ns / 1ps
// mfa_in_if / mfa_out_if: valid-ready channels of the mixed fraction unit
// depends on mfa_pkg for field widths

interface mfa_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          mode;
    logic signed [mfa_pkg::OP_BITS-1:0]  a_whole;
    logic [mfa_pkg::OP_BITS-1:0]         a_num;
    logic [mfa_pkg::OP_BITS-1:0]         a_den;
    logic signed [mfa_pkg::OP_BITS-1:0]  b_whole;
    logic [mfa_pkg::OP_BITS-1:0]         b_num;
    logic [mfa_pkg::OP_BITS-1:0]         b_den;

    modport source (output valid, mode, a_whole, a_num, a_den, b_whole, b_num, b_den,
                    input ready);
    modport sink   (input valid, mode, a_whole, a_num, a_den, b_whole, b_num, b_den,
                    output ready);
endinterface

interface mfa_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mfa_pkg::WHOLE_W-1:0]  res_whole;
    logic signed [mfa_pkg::NUM_W-1:0]    res_num;
    logic [mfa_pkg::DEN_W-1:0]           res_den;
    logic [1:0]                          status;

    modport source (output valid, res_whole, res_num, res_den, status, input ready);
    modport sink   (input valid, res_whole, res_num, res_den, status, output ready);
endinterface

### sv/mfa_div.sv
`timescale 1ns / 1ps
// mfa_div: restoring shift-subtract divider, one quotient bit per cycle
// depends on mfa_pkg

module mfa_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mfa_pkg::MAG_W-1:0]   dividend,
    input  logic [mfa_pkg::MAG_W-1:0]   divisor,
    output logic                        done,
    output logic [mfa_pkg::MAG_W-1:0]   quot,
    output logic [mfa_pkg::MAG_W-1:0]   rem
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [mfa_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [mfa_pkg::MAG_W-1:0]   quo_reg, quo_next;
    logic [mfa_pkg::MAG_W:0]     rem_reg, rem_next;
    logic [mfa_pkg::MAG_W-1:0]   dvs_reg, dvs_next;
    logic [mfa_pkg::MAG_W:0]     shifted;
    logic                        fits;

    assign shifted = {rem_reg[mfa_pkg::MAG_W-1:0], quo_reg[mfa_pkg::MAG_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = mfa_pkg::CNT_W'(mfa_pkg::MAG_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[mfa_pkg::MAG_W-2:0], fits};
            rem_next = fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mfa_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg[mfa_pkg::MAG_W-1:0];

endmodule

### sv/mfa_gcd.sv
`timescale 1ns / 1ps
// mfa_gcd: binary gcd of two nonzero magnitudes, one shift or subtract per cycle
// depends on mfa_pkg

module mfa_gcd (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mfa_pkg::MAG_W-1:0]   x_in,
    input  logic [mfa_pkg::MAG_W-1:0]   y_in,
    output logic                        done,
    output logic [mfa_pkg::MAG_W-1:0]   g
);

    logic                        busy_reg, busy_next;
    logic [mfa_pkg::MAG_W-1:0]   x_reg, x_next;
    logic [mfa_pkg::MAG_W-1:0]   y_reg, y_next;
    logic [mfa_pkg::SH_W-1:0]    k_reg, k_next;
    logic                        same;

    assign same = x_reg == y_reg;
    assign done = busy_reg && same;
    assign g    = x_reg << k_reg;

    always_comb
    begin
        busy_next = busy_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        k_next    = k_reg;
        if (start)
        begin
            busy_next = 1'b1;
            x_next    = x_in;
            y_next    = y_in;
            k_next    = '0;
        end
        else if (busy_reg)
        begin
            priority if (same)
                busy_next = 1'b0;
            else if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!x_reg[0])
                x_next = x_reg >> 1;
            else if (!y_reg[0])
                y_next = y_reg >> 1;
            else if (x_reg > y_reg)
                x_next = x_reg - y_reg;
            else
                y_next = y_reg - x_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        k_reg <= k_next;
    end

endmodule

### sv/mixed_fraction_arithmetic_unit.sv
`timescale 1ns / 1ps
// mixed_fraction_arithmetic_unit: add, subtract, multiply or divide two mixed
// fractions, reduce by gcd and split into whole part and remainder
// depends on mfa_pkg, mfa_if, mfa_div, mfa_gcd
//
//  channel  dir  payload                                        handshake
//  req      in   mode, a_whole/num/den, b_whole/num/den         valid/ready
//  rsp      out  res_whole, res_num, res_den, status            valid/ready
//
// one transaction at a time: req.ready is high only while the sequencer idles
// each transaction runs five products through one shared 18x18
// multiplier, the binary gcd, then three passes of the shared divider
// zero operand denominator or divide by zero skip the gcd and the divider
// reset clears the sequencer and the output valid; no clearing pass
// a finished result waits in its own register, so a stalled rsp only holds
// the sequencer when a second result is ready before the first was taken

module mixed_fraction_arithmetic_unit (
    input  logic       clk,
    input  logic       rst_n,
    mfa_in_if.sink     req,
    mfa_out_if.source  rsp
);

    localparam int OPB = mfa_pkg::OP_BITS;
    localparam int PW  = mfa_pkg::PW;
    localparam int NW  = mfa_pkg::NW;
    localparam int MW  = mfa_pkg::MAG_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_MUL  = 8'b00000010,
        S_MAG  = 8'b00000100,
        S_GCD  = 8'b00001000,
        S_DIVN = 8'b00010000,
        S_DIVD = 8'b00100000,
        S_DIVQ = 8'b01000000,
        S_FIN  = 8'b10000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [2:0]               step_reg, step_next;

    // captured operands
    logic [1:0]               mode_reg;
    logic signed [OPB-1:0]    aw_reg, bw_reg;
    logic [OPB-1:0]           an_reg, ad_reg, bn_reg, bd_reg;

    // improper fractions and products
    logic signed [PW-1:0]     a_reg, a_next, b_reg, b_next;
    logic signed [NW-1:0]     n_reg, n_next, d_reg, d_next;
    logic signed [NW-1:0]     prod_reg;
    logic signed [PW-1:0]     mul_x, mul_y;
    logic signed [NW-1:0]     mul_p;
    logic signed [PW-1:0]     aw_e, ad_e, an_e, bw_e, bd_e, bn_e;

    // magnitudes after the sign is taken off
    logic                     neg_reg, neg_next;
    logic [MW-1:0]            un_reg, un_next, ud_reg, ud_next, g_reg, g_next;
    logic signed [NW-1:0]     n_abs, d_abs;

    // finished result waiting for the output register
    logic signed [mfa_pkg::WHOLE_W-1:0] fw_reg, fw_next;
    logic signed [mfa_pkg::NUM_W-1:0]   fn_reg, fn_next;
    logic [mfa_pkg::DEN_W-1:0]          fd_reg, fd_next;
    mfa_pkg::status_t                   fs_reg, fs_next;

    // output register
    logic                               ov_reg, ov_next;
    logic signed [mfa_pkg::WHOLE_W-1:0] ow_reg;
    logic signed [mfa_pkg::NUM_W-1:0]   on_reg;
    logic [mfa_pkg::DEN_W-1:0]          od_reg;
    mfa_pkg::status_t                   os_reg;
    logic                               out_load;

    // divider and gcd units
    logic                     div_start, div_done, gcd_start, gcd_done;
    logic [MW-1:0]            div_dvd, div_dvs, div_q, div_r, gcd_g;

    logic                     accept;
    logic [mfa_pkg::DEN_W-1:0] r16;

    assign accept    = req.valid && req.ready;
    assign req.ready = state_reg == S_IDLE;

    assign aw_e = PW'(aw_reg);
    assign bw_e = PW'(bw_reg);
    assign an_e = {{(PW - OPB){1'b0}}, an_reg};
    assign ad_e = {{(PW - OPB){1'b0}}, ad_reg};
    assign bn_e = {{(PW - OPB){1'b0}}, bn_reg};
    assign bd_e = {{(PW - OPB){1'b0}}, bd_reg};

    assign n_abs = n_reg[NW-1] ? -n_reg : n_reg;
    assign d_abs = d_reg[NW-1] ? -d_reg : d_reg;
    assign r16   = div_r[mfa_pkg::DEN_W-1:0];

    // shared multiplier operand select, product registered every cycle
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        unique case (step_reg)
            3'd0:
            begin
                mul_x = aw_e;
                mul_y = ad_e;
            end
            3'd1:
            begin
                mul_x = bw_e;
                mul_y = bd_e;
            end
            3'd2:
            begin
                mul_x = ad_e;
                mul_y = bd_e;
            end
            3'd3:
            begin
                mul_x = a_reg;
                mul_y = bd_e;
            end
            3'd4:
            begin
                unique case (mfa_pkg::mode_t'(mode_reg))
                    mfa_pkg::MODE_ADD,
                    mfa_pkg::MODE_SUB:
                    begin
                        mul_x = b_reg;
                        mul_y = ad_e;
                    end
                    mfa_pkg::MODE_MUL:
                    begin
                        mul_x = a_reg;
                        mul_y = b_reg;
                    end
                    default:
                    begin
                        mul_x = ad_e;
                        mul_y = b_reg;
                    end
                endcase
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    // divider operand select by phase
    always_comb
    begin
        div_dvd = un_reg;
        div_dvs = ud_reg;
        priority case (1'b1)
            state_reg == S_GCD:
            begin
                div_dvd = un_reg;
                div_dvs = gcd_g;
            end
            state_reg == S_DIVN:
            begin
                div_dvd = ud_reg;
                div_dvs = g_reg;
            end
            default:
            begin
                div_dvd = un_reg;
                div_dvs = div_q;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        neg_next   = neg_reg;
        un_next    = un_reg;
        ud_next    = ud_reg;
        g_next     = g_reg;
        fw_next    = fw_reg;
        fn_next    = fn_reg;
        fd_next    = fd_reg;
        fs_next    = fs_reg;
        div_start  = 1'b0;
        gcd_start  = 1'b0;
        out_load   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    step_next = '0;
                    fw_next   = '0;
                    fn_next   = '0;
                    fd_next   = mfa_pkg::DEN_W'(1);
                    fs_next   = mfa_pkg::ST_OK;
                    // zero operand denominator wins over every other case
                    if (req.a_den == '0 || req.b_den == '0)
                    begin
                        fs_next    = mfa_pkg::ST_ZERO_DEN;
                        state_next = S_FIN;
                    end
                    else
                        state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                step_next = step_reg + 1'b1;
                unique case (step_reg)
                    3'd1: a_next = prod_reg[PW-1:0] + an_e;
                    3'd2: b_next = prod_reg[PW-1:0] + bn_e;
                    3'd3: d_next = prod_reg;
                    3'd4: n_next = prod_reg;
                    3'd5:
                    begin
                        state_next = S_MAG;
                        unique case (mfa_pkg::mode_t'(mode_reg))
                            mfa_pkg::MODE_ADD: n_next = n_reg + prod_reg;
                            mfa_pkg::MODE_SUB: n_next = n_reg - prod_reg;
                            mfa_pkg::MODE_MUL: n_next = prod_reg;
                            default:
                            begin
                                d_next = prod_reg;
                                if (b_reg == '0)
                                begin
                                    fs_next    = mfa_pkg::ST_DIV_ZERO;
                                    state_next = S_FIN;
                                end
                            end
                        endcase
                    end
                    default: ;
                endcase
            end
            S_MAG:
            begin
                neg_next = n_reg[NW-1] != d_reg[NW-1];
                un_next  = n_abs[MW-1:0];
                ud_next  = d_abs[MW-1:0];
                if (n_abs[MW-1:0] == '0)
                    state_next = S_FIN;
                else
                begin
                    gcd_start  = 1'b1;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (gcd_done)
                begin
                    g_next     = gcd_g;
                    div_start  = 1'b1;
                    state_next = S_DIVN;
                end
            end
            S_DIVN:
            begin
                if (div_done)
                begin
                    un_next    = div_q;
                    div_start  = 1'b1;
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (div_done)
                begin
                    ud_next = div_q;
                    if (div_q > mfa_pkg::DEN_MAX)
                    begin
                        fs_next    = mfa_pkg::ST_RANGE;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIVQ;
                    end
                end
            end
            S_DIVQ:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                    if (div_q > (neg_reg ? mfa_pkg::WHOLE_NEG_MAX : mfa_pkg::WHOLE_POS_MAX))
                        fs_next = mfa_pkg::ST_RANGE;
                    else
                    begin
                        fw_next = neg_reg ? -div_q[mfa_pkg::WHOLE_W-1:0]
                                          : div_q[mfa_pkg::WHOLE_W-1:0];
                        fn_next = neg_reg ? -{1'b0, r16} : {1'b0, r16};
                        fd_next = (div_r == '0) ? mfa_pkg::DEN_W'(1)
                                                : ud_reg[mfa_pkg::DEN_W-1:0];
                    end
                end
            end
            S_FIN:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (rsp.ready)
            ov_next = 1'b0;
        if (out_load)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            aw_reg   <= req.a_whole;
            an_reg   <= req.a_num;
            ad_reg   <= req.a_den;
            bw_reg   <= req.b_whole;
            bn_reg   <= req.b_num;
            bd_reg   <= req.b_den;
        end
        prod_reg <= mul_p;
        a_reg    <= a_next;
        b_reg    <= b_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        un_reg   <= un_next;
        ud_reg   <= ud_next;
        g_reg    <= g_next;
        fw_reg   <= fw_next;
        fn_reg   <= fn_next;
        fd_reg   <= fd_next;
        fs_reg   <= fs_next;
        if (out_load)
        begin
            ow_reg <= fw_reg;
            on_reg <= fn_reg;
            od_reg <= fd_reg;
            os_reg <= fs_reg;
        end
    end

    assign rsp.valid     = ov_reg;
    assign rsp.res_whole = ow_reg;
    assign rsp.res_num   = on_reg;
    assign rsp.res_den   = od_reg;
    assign rsp.status    = os_reg;

    mfa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    mfa_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .x_in  (n_abs[MW-1:0]),
        .y_in  (d_abs[MW-1:0]),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    // any error result is zero over one
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != mfa_pkg::ST_OK |->
            rsp.res_whole == '0 && rsp.res_num == '0 && rsp.res_den == mfa_pkg::DEN_W'(1))
        else $error("error result not cleared");

    // no remainder means denominator one
    a_den_one: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.res_num == '0 |-> rsp.res_den == mfa_pkg::DEN_W'(1))
        else $error("denominator not one on zero remainder");

    // a new result only leaves the sequencer as it goes idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> state_reg == S_IDLE && ov_reg)
        else $error("result load without return to idle");

    // the gcd never finishes while the sequencer is elsewhere
    a_gcd_phase: assert property (@(posedge clk) disable iff (!rst_n)
        gcd_done |-> state_reg == S_GCD)
        else $error("gcd completion outside gcd phase");

endmodule
